FILE: design/window_iteration_range_score_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the window iteration range score block
// Clocked on clk_i, disabled while rst_ni is low; empty when NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef WINDOW_ITERATION_RANGE_SCORE_TOP_ASSERT_SVH
`define WINDOW_ITERATION_RANGE_SCORE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define WIRS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define WIRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WIRS_ASSERT_IMPL(lbl, ante, cons)
`define WIRS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: design/wirs_pkg.sv
// ----------------------------------------------------------------------------
// wirs_pkg
// Types and constants shared by the window iteration range score block.
// ----------------------------------------------------------------------------
package wirs_pkg;

  // signed window coordinate: covers -255 .. 511
  localparam int unsigned COORD_W = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 2'd2;

  // reset values of the configuration registers
  localparam logic [8:0] FRAME_WIDTH_RST = 9'd256;
  localparam logic [8:0] FRAME_HEIGHT_RST = 9'd256;
  localparam logic [15:0] ITER_LIMIT_RST = 16'd256;

  // item action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] pixel_index;
    logic [15:0] pixel_iterations;
    logic [7:0]  center_x;
    logic [7:0]  center_y;
    logic [8:0]  window_width;
    logic [8:0]  window_height;
  } in_item_t;

  typedef struct packed {
    logic [15:0] min_iterations;
    logic [15:0] max_iterations;
    logic [31:0] diversity_score;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic write;    // store the incoming pixel
    logic load;     // capture the clamped window bounds
    logic setup;    // start the walk counters at the window origin
    logic step;     // read one pixel and advance the walk
    logic mult;     // form the score
    logic publish;  // move the result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;     // clamped window holds no pixel
    logic last;      // walk is at the final pixel
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage

FILE: design/wirs_ram.sv
// ----------------------------------------------------------------------------
// wirs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wirs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/wirs_ctrl.sv
// ----------------------------------------------------------------------------
// wirs_ctrl
// Sequencer: takes items, walks a query window, publishes the result.
// ----------------------------------------------------------------------------
`include "window_iteration_range_score_top_assert.svh"

module wirs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_action_i,
  output logic                 in_stall_o,
  input  wirs_pkg::dp_status_t status_i,
  output wirs_pkg::ctrl_cmd_t  cmd_o
);
  import wirs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_MULT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       take;

  assign in_stall_o = (state_q != S_IDLE);
  assign take = in_valid_i && (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          if (in_action_i == ACT_QUERY) begin
            cmd_o.load = 1'b1;
            state_d = S_SETUP;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = status_i.empty ? S_MULT : S_WALK;
      end
      S_WALK: begin
        cmd_o.step = 1'b1;
        if (status_i.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_MULT;
      end
      S_MULT: begin
        cmd_o.mult = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `WIRS_ASSERT_NEXT(a_last_drains, (state_q == S_WALK) && status_i.last, state_q == S_DRAIN)
  `WIRS_ASSERT_NEXT(a_empty_skips, (state_q == S_SETUP) && status_i.empty, state_q == S_MULT)
  `WIRS_ASSERT_IMPL(a_publish_free, cmd_o.publish, status_i.out_free && !in_stall_o == 1'b0)

endmodule

FILE: design/wirs_dp.sv
// ----------------------------------------------------------------------------
// wirs_dp
// Datapath: configuration, frame store, window bounds, walk counters,
// min/max tracking, score multiplier and output register.
// ----------------------------------------------------------------------------
`include "window_iteration_range_score_top_assert.svh"

module wirs_dp #(
  parameter int unsigned MAX_WIDTH = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned ITER_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wirs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wirs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wirs_pkg::in_item_t                  in_data_i,
  input  wirs_pkg::ctrl_cmd_t                 cmd_i,
  output wirs_pkg::dp_status_t                status_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output wirs_pkg::out_item_t                 out_data_o
);
  import wirs_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  logic [8:0]  cfg_width_q, cfg_height_q;
  logic [15:0] cfg_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q <= FRAME_WIDTH_RST;
      cfg_height_q <= FRAME_HEIGHT_RST;
      cfg_limit_q <= ITER_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  cfg_width_q <= cfg_data_i[8:0];
        CFG_FRAME_HEIGHT: cfg_height_q <= cfg_data_i[8:0];
        CFG_ITER_LIMIT:   cfg_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // saturate frame size to the store geometry
  logic [8:0] fw, fh;
  assign fw = (32'(cfg_width_q) > MAX_WIDTH) ? 9'(MAX_WIDTH) : cfg_width_q;
  assign fh = (32'(cfg_height_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : cfg_height_q;

  // frame store write: drop indexes beyond the store
  logic                 ram_we;
  logic [ADDR_W+15:0]   waddr_ext;
  logic [ITER_BITS+15:0] wdata_ext;

  assign ram_we = cmd_i.write && ({16'b0, in_data_i.pixel_index} < 32'(DEPTH));
  assign waddr_ext = {{ADDR_W{1'b0}}, in_data_i.pixel_index};
  assign wdata_ext = {{ITER_BITS{1'b0}}, in_data_i.pixel_iterations};

  // window bounds: start at centre minus half size, clamp to the frame
  logic signed [COORD_W-1:0] x0, y0, xe, ye, x1, y1, x2, y2, fw_s, fh_s;

  always_comb begin
    fw_s = $signed({2'b00, fw});
    fh_s = $signed({2'b00, fh});
    x0 = $signed({3'b000, in_data_i.center_x}) - $signed({3'b000, in_data_i.window_width[8:1]});
    y0 = $signed({3'b000, in_data_i.center_y}) - $signed({3'b000, in_data_i.window_height[8:1]});
    xe = x0 + $signed({2'b00, in_data_i.window_width});
    ye = y0 + $signed({2'b00, in_data_i.window_height});
    x1 = (x0 < 0) ? '0 : x0;
    y1 = (y0 < 0) ? '0 : y0;
    x2 = (xe > fw_s) ? fw_s : xe;
    y2 = (ye > fh_s) ? fh_s : ye;
  end

  logic signed [COORD_W-1:0] x1_q, y1_q, x2_q, y2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x1_q <= x1;
      y1_q <= y1;
      x2_q <= x2;
      y2_q <= y2;
    end
  end

  // walk counters and running row base address
  logic [COORD_W-1:0]         px_q, py_q;
  logic [ADDR_W-1:0]          row_base_q;
  logic [17:0]                base_prod;
  logic [ADDR_W+17:0]         base_ext;
  logic [ADDR_W+8:0]          next_base;
  logic [ADDR_W+COORD_W-1:0]  raddr_ext;
  logic                       row_end;

  assign base_prod = y1_q[8:0] * fw;
  assign base_ext = {{ADDR_W{1'b0}}, base_prod};
  assign next_base = {9'b0, row_base_q} + {{ADDR_W{1'b0}}, fw};
  assign raddr_ext = {{COORD_W{1'b0}}, row_base_q} + {{ADDR_W{1'b0}}, px_q};
  assign row_end = (px_q == COORD_W'(x2_q - COORD_W'(1)));

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      px_q <= x1_q;
      py_q <= y1_q;
      row_base_q <= base_ext[ADDR_W-1:0];
    end else if (cmd_i.step) begin
      if (row_end) begin
        px_q <= x1_q;
        py_q <= py_q + COORD_W'(1);
        row_base_q <= next_base[ADDR_W-1:0];
      end else begin
        px_q <= px_q + COORD_W'(1);
      end
    end
  end

  // frame store
  logic [ITER_BITS-1:0] rdata;

  wirs_ram #(
    .WIDTH(ITER_BITS),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr_ext[ADDR_W-1:0]),
    .wdata_i(wdata_ext[ITER_BITS-1:0]),
    .re_i   (cmd_i.step),
    .raddr_i(raddr_ext[ADDR_W-1:0]),
    .rdata_o(rdata)
  );

  // read data arrives in the cycle after the step
  logic rd_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.step;
    end
  end

  // track min and max of counts below the limit
  logic [ITER_BITS+15:0] rdata_ext;
  logic [15:0]           pix;
  logic [15:0]           mn_q, mx_q;

  assign rdata_ext = {16'b0, rdata};
  assign pix = rdata_ext[15:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mn_q <= cfg_limit_q;
      mx_q <= '0;
    end else if (rd_pend_q && (pix < cfg_limit_q)) begin
      if (pix < mn_q) begin
        mn_q <= pix;
      end
      if (pix > mx_q) begin
        mx_q <= pix;
      end
    end
  end

  // score: an empty window has max 0, so the product is 0 as well
  logic [31:0] score_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      score_q <= {16'b0, mx_q - mn_q} * {16'b0, mx_q};
    end
  end

  // output register
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_q.min_iterations <= mn_q;
      out_q.max_iterations <= mx_q;
      out_q.diversity_score <= score_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // status back to the controller
  assign status_o.empty = !(x1_q < x2_q) || !(y1_q < y2_q);
  assign status_o.last = row_end && (py_q == COORD_W'(y2_q - COORD_W'(1)));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  `WIRS_ASSERT_IMPL(a_pend_after_step, rd_pend_q, $past(cmd_i.step))
  `WIRS_ASSERT_NEXT(a_publish_valid, cmd_i.publish, out_valid_q)
  `WIRS_ASSERT_IMPL(a_no_write_in_walk, ram_we, !rd_pend_q && !cmd_i.step)

endmodule

FILE: design/window_iteration_range_score_top.sv
// ----------------------------------------------------------------------------
// window_iteration_range_score_top
// Frame of escape iteration counts with a windowed min/max/score query.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  wirs_pkg::in_item_t
//   out      output     out_valid_o / out_stall_i wirs_pkg::out_item_t
//   cfg      input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// A write item is taken while idle; writes can stream at one item per cycle.
// A query holds the input while the block sets up, walks the clamped window
// one pixel per cycle, forms the score and publishes; an empty window skips the walk.
// The frame store has no reset and no clearing pass; read only written pixels.
// One finished result waits in the output register; the next query runs while
// it waits and holds its own result until the register frees.
// ----------------------------------------------------------------------------
module window_iteration_range_score_top #(
  parameter int unsigned MAX_WIDTH = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned ITER_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  wirs_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output wirs_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [wirs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wirs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wirs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  wirs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_action_i(in_data_i.action),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath and frame store
  wirs_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .ITER_BITS (ITER_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: verif/window_score_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window score checker
// Watches the item, result and register ports of the window iteration range
// score block. It keeps its own frame copy and register copy, predicts the
// min/max/score result of every accepted query item and compares each
// accepted result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module window_score_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  wirs_pkg::in_item_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  wirs_pkg::out_item_t             out_data_i,
  input  logic                            cfg_we_i,
  input  logic [wirs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wirs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import wirs_pkg::*;

  localparam int FRAME_MAX_W = 256;
  localparam int FRAME_MAX_H = 256;

  // shadow of the frame store and the registers
  logic [15:0] frame_copy [FRAME_MAX_W*FRAME_MAX_H];
  logic [8:0]  frame_w_reg;
  logic [8:0]  frame_h_reg;
  logic [15:0] iter_limit_reg;

  // predicted results, oldest first
  out_item_t   expected_scores [$];

  // walk the clamped window and form min, max and score
  function automatic out_item_t window_range_score(in_item_t q);
    int          efw, efh, x0, y0, x1, y1, x2, y2, py, px;
    logic [15:0] lo, hi, v;
    logic [31:0] span;
    bit          found;
    out_item_t   r;
    efw = (int'(frame_w_reg) > FRAME_MAX_W) ? FRAME_MAX_W : int'(frame_w_reg);
    efh = (int'(frame_h_reg) > FRAME_MAX_H) ? FRAME_MAX_H : int'(frame_h_reg);
    x0 = int'(q.center_x) - int'(q.window_width) / 2;
    y0 = int'(q.center_y) - int'(q.window_height) / 2;
    x1 = (x0 < 0) ? 0 : x0;
    y1 = (y0 < 0) ? 0 : y0;
    x2 = (x0 + int'(q.window_width) > efw) ? efw : x0 + int'(q.window_width);
    y2 = (y0 + int'(q.window_height) > efh) ? efh : y0 + int'(q.window_height);
    lo = iter_limit_reg;
    hi = '0;
    found = 1'b0;
    for (py = y1; py < y2; py++) begin
      for (px = x1; px < x2; px++) begin
        v = frame_copy[py * efw + px];
        // skip counts at or above the limit
        if (v < iter_limit_reg) begin
          found = 1'b1;
          if (v < lo) lo = v;
          if (v > hi) hi = v;
        end
      end
    end
    span = hi - lo;
    r.min_iterations = lo;
    r.max_iterations = hi;
    r.diversity_score = found ? span * hi : '0;
    return r;
  endfunction

  // track registers and writes, predict queries, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      frame_w_reg <= FRAME_WIDTH_RST;
      frame_h_reg <= FRAME_HEIGHT_RST;
      iter_limit_reg <= ITER_LIMIT_RST;
      expected_scores.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH: frame_w_reg <= cfg_data_i[8:0];
          CFG_FRAME_HEIGHT: frame_h_reg <= cfg_data_i[8:0];
          CFG_ITER_LIMIT: iter_limit_reg <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      // compare the accepted result with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_scores.size() == 0) begin
          $display("%0t: result with nothing pending: actual %h", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_scores.pop_front();
          if (out_data_i.min_iterations !== want.min_iterations ||
              out_data_i.max_iterations !== want.max_iterations ||
              out_data_i.diversity_score !== want.diversity_score) begin
            $display("%0t: expected %h/%h/%h, actual %h/%h/%h (min/max/score)",
                     $time, want.min_iterations, want.max_iterations,
                     want.diversity_score, out_data_i.min_iterations,
                     out_data_i.max_iterations, out_data_i.diversity_score);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end

      // store written pixels, predict query items
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.action == ACT_WRITE) begin
          frame_copy[in_data_i.pixel_index] <= in_data_i.pixel_iterations;
        end else begin
          expected_scores.insert(expected_scores.size(), window_range_score(in_data_i));
        end
      end
      pending_o <= expected_scores.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window iteration range score testbench
// Drives pixel write and window query items into the block under random
// idling on both channels, steps through several frame and limit settings
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import wirs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 400;
  localparam int BIG_AREA = 64;

  logic                  clk_i = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;

  // stimulus-side view of the frame
  bit                    pix_written [65536];
  int                    cur_fw;
  int                    cur_fh;
  int                    cur_lim;
  bit                    burst;
  logic                  hold_go = 1'b0;
  int                    sent_items = 0;

  // receiver stall state
  bit                    hold_done;
  int                    hold_left;
  int                    stall_run;
  int                    stall_pick;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  window_iteration_range_score_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  window_score_checker score_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver: one long hold on request, otherwise random runs of stall
  always @(negedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(0, 20);
      end else if (stall_pick < 90) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(10, 40);
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one item and hold it until accepted
  task automatic send_item(in_item_t item);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (in_stall);
    sent_items++;
  endtask

  // stop offering, wait for every pending result, then let the block settle
  task automatic drain_block();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // write all three registers on consecutive cycles
  task automatic load_config(logic [15:0] fw_data, logic [15:0] fh_data,
                             logic [15:0] lim_data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data <= fw_data;
    @(negedge clk_i);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data <= fh_data;
    @(negedge clk_i);
    cfg_index <= CFG_ITER_LIMIT;
    cfg_data <= lim_data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cur_fw = (int'(fw_data[8:0]) > 256) ? 256 : int'(fw_data[8:0]);
    cur_fh = (int'(fh_data[8:0]) > 256) ? 256 : int'(fh_data[8:0]);
    cur_lim = int'(lim_data);
  endtask

  // count value: mostly below the limit, sometimes any
  function automatic logic [15:0] pick_count();
    if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, cur_lim - 1));
    return 16'($urandom);
  endfunction

  // write item with random query fields
  task automatic write_pixel(logic [15:0] idx, logic [15:0] count);
    in_item_t item;
    item = in_item_t'({$urandom, $urandom, $urandom});
    item.action = ACT_WRITE;
    item.pixel_index = idx;
    item.pixel_iterations = count;
    pix_written[idx] = 1'b1;
    send_item(item);
  endtask

  // load every unwritten pixel of the window, then send the query
  task automatic ask_window(int cx, int cy, int ww, int wh);
    int       x0, y0, x1, y1, x2, y2, py, px;
    in_item_t item;
    x0 = cx - ww / 2;
    y0 = cy - wh / 2;
    x1 = (x0 < 0) ? 0 : x0;
    y1 = (y0 < 0) ? 0 : y0;
    x2 = (x0 + ww > cur_fw) ? cur_fw : x0 + ww;
    y2 = (y0 + wh > cur_fh) ? cur_fh : y0 + wh;
    for (py = y1; py < y2; py++) begin
      for (px = x1; px < x2; px++) begin
        if (!pix_written[py * cur_fw + px]) write_pixel(16'(py * cur_fw + px), pick_count());
      end
    end
    item = in_item_t'({$urandom, $urandom, $urandom});
    item.action = ACT_QUERY;
    item.center_x = 8'(cx);
    item.center_y = 8'(cy);
    item.window_width = 9'(ww);
    item.window_height = 9'(wh);
    send_item(item);
  endtask

  // window size: zero, the full 256 or any size up to 256 where the frame is small, else modest
  function automatic int pick_size(int dim, bit big_ok);
    int r, cap;
    r = $urandom_range(0, 99);
    cap = dim + 4;
    if (!big_ok && cap > 6) cap = 6;
    if (cap > 256) cap = 256;
    if (r < 8) return 0;
    if (big_ok && r < 16) return 256;
    if (big_ok && r < 20) return $urandom_range(0, 256);
    return $urandom_range(1, cap);
  endfunction

  task automatic random_query();
    int cx, cy, ww, wh;
    bit big_ok;
    big_ok = (cur_fw * cur_fh <= BIG_AREA);
    cx = (cur_fw > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, cur_fw - 1)
                                                    : $urandom_range(0, 255);
    cy = (cur_fh > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, cur_fh - 1)
                                                    : $urandom_range(0, 255);
    ww = pick_size(cur_fw, big_ok);
    wh = pick_size(cur_fh, big_ok);
    ask_window(cx, cy, ww, wh);
  endtask

  task automatic random_write();
    int area;
    area = cur_fw * cur_fh;
    if (area > 0 && $urandom_range(0, 9) < 7)
      write_pixel(16'($urandom_range(0, area - 1)), pick_count());
    else
      write_pixel(16'($urandom), pick_count());
  endtask

  // one setting: settle, load registers, mixed items with a drain half way
  task automatic run_phase(logic [15:0] fw_data, logic [15:0] fh_data,
                           logic [15:0] lim_data, int n_items);
    int start_count;
    bit drained;
    drain_block();
    load_config(fw_data, fh_data, lim_data);
    burst = ($urandom_range(0, 2) == 0);
    start_count = sent_items;
    drained = 1'b0;
    while (sent_items - start_count < n_items) begin
      if (!drained && sent_items - start_count >= n_items / 2) begin
        drain_block();
        drained = 1'b1;
      end
      if ($urandom_range(0, 1) != 0) random_write();
      else random_query();
    end
  endtask

  function automatic logic [15:0] pick_dim();
    return 16'($urandom_range(1, 32)) | 16'($urandom_range(0, 127) << 9);
  endfunction

  function automatic logic [15:0] pick_limit();
    if ($urandom_range(0, 1) != 0) return 16'($urandom_range(1, 512));
    return 16'($urandom_range(1, 65535));
  endfunction

  // stimulus and verdict
  initial begin
    logic [15:0] seed_counts [12];
    int i;
    seed_counts = '{16'd0, 16'hFFFF, 16'd9, 16'd10, 16'd3, 16'd11,
                    16'd5, 16'd7, 16'd2, 16'd9, 16'd1, 16'd8};
    repeat (9) @(negedge clk_i);
    rst_n <= 1'b1;

    // directed: 4x3 frame, limit 10
    load_config(16'd4, 16'd3, 16'd10);
    for (i = 0; i < 12; i++) write_pixel(16'(i), seed_counts[i]);
    write_pixel(16'hFFFF, 16'hFFFF);
    ask_window(2, 1, 256, 256);   // whole frame, clamped on every side
    ask_window(0, 0, 0, 5);       // zero width
    ask_window(0, 0, 5, 0);       // zero height
    ask_window(255, 255, 8, 8);   // entirely off the frame
    ask_window(1, 1, 1, 1);       // single pixel above the limit: nothing valid
    ask_window(0, 0, 1, 1);       // single pixel holding zero
    ask_window(3, 0, 3, 3);       // partly off the right and top edges

    // register extremes
    run_phase(16'd256, 16'd256, 16'd256, 50);
    run_phase(16'd1, 16'd256, 16'd65535, 50);
    // long receiver hold while the sender keeps offering items
    drain_block();
    hold_go <= 1'b1;
    run_phase(16'd256, 16'd1, 16'd1, 50);
    run_phase(16'd0, 16'd8, 16'd100, 30);
    run_phase(16'd16, 16'd0, 16'd4000, 30);
    run_phase(16'hFFFF, 16'd3, 16'd300, 50);
    run_phase(16'd7, 16'h01FF, pick_limit(), 50);

    // random settings
    for (i = 0; i < 6; i++) run_phase(pick_dim(), pick_dim(), pick_limit(), 50);

    drain_block();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
